// File: src/fk3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fk3_pkg
// shared widths, constants and the arctangent table of the arm kinematics
// ----------------------------------------------------------------------------
package fk3_pkg;

  localparam int unsigned CordicStagesDef = 16;
  localparam int unsigned CordicStagesMax = 24;
  localparam int unsigned Lanes           = 3;

  localparam int unsigned AngW  = 15;
  localparam int unsigned LenW  = 20;
  localparam int unsigned OffW  = 21;
  localparam int unsigned OutW  = 22;
  localparam int unsigned CfgW  = 21;
  localparam int unsigned IdxW  = 2;
  localparam int unsigned ZW    = 33;
  localparam int unsigned XW    = 34;

  localparam logic [IdxW-1:0] RegUpper  = 2'd0;
  localparam logic [IdxW-1:0] RegLower  = 2'd1;
  localparam logic [IdxW-1:0] RegOffset = 2'd2;

  localparam logic [LenW-1:0] UpperRst  = 20'd248324;
  localparam logic [LenW-1:0] LowerRst  = 20'd297626;
  localparam logic [OffW-1:0] OffsetRst = 21'd39804;

  localparam logic [XW-1:0] GainQ30 = 34'd652032874;
  localparam logic [27:0]   AngToBin = 28'd85445660;

  function automatic logic [31:0] atan_bin(input int unsigned idx);
    logic [31:0] r;
    case (idx)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // clamp a 27 bit value to the symmetric output range
  function automatic logic signed [OutW-1:0] sat_out(input logic signed [26:0] v);
    logic signed [26:0] hi;
    hi = 27'sd2097151;
    if (v > hi) begin
      return hi[OutW-1:0];
    end else if (v < -hi) begin
      return -hi[OutW-1:0];
    end
    return v[OutW-1:0];
  endfunction

endpackage
`default_nettype wire

// File: src/three_joint_arm_forward_kinematics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// three_joint_arm_forward_kinematics
// end point of a base, shoulder and elbow arm from its three joint angles
// ----------------------------------------------------------------------------
// Accepts one set of joint angles per clock while not stalled and returns the
// end point position through the angle scaling register, the cordic pipeline
// (the folded angle register plus one register per iteration) and the link
// product, reach sum, projection product and output registers. The whole
// pipeline stalls when the output request is not taken; the user must write
// link lengths and offset through the cfg port only while idle (not enforced).
module three_joint_arm_forward_kinematics #(
  parameter int unsigned CORDIC_STAGES = fk3_pkg::CordicStagesDef
) (
  input  wire                                    clk_i,
  input  wire                                    rst_ni,
  input  wire                                    cfg_we_i,
  input  wire  logic [fk3_pkg::IdxW-1:0]         cfg_idx_i,
  input  wire  logic [fk3_pkg::CfgW-1:0]         cfg_data_i,
  input  wire                                    in_valid_i,
  output logic                                   in_ready_o,
  input  wire  logic signed [fk3_pkg::AngW-1:0]  base_angle_i,
  input  wire  logic signed [fk3_pkg::AngW-1:0]  shoulder_angle_i,
  input  wire  logic signed [fk3_pkg::AngW-1:0]  elbow_angle_i,
  output logic                                   out_valid_o,
  input  wire                                    out_ready_i,
  output logic signed [fk3_pkg::OutW-1:0]        pos_x_o,
  output logic signed [fk3_pkg::OutW-1:0]        pos_y_o,
  output logic signed [fk3_pkg::OutW-1:0]        pos_z_o
);
  import fk3_pkg::*;

  localparam int unsigned NStg = (CORDIC_STAGES > CordicStagesMax) ?
                                 CordicStagesMax : CORDIC_STAGES;

  logic [LenW-1:0] l1_q, l2_q;
  logic [OffW-1:0] off_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q  <= UpperRst;
      l2_q  <= LowerRst;
      off_q <= OffsetRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegUpper:  l1_q  <= cfg_data_i[LenW-1:0];
        RegLower:  l2_q  <= cfg_data_i[LenW-1:0];
        RegOffset: off_q <= cfg_data_i[OffW-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en         = !out_vld_q || out_ready_i;
  assign in_ready_o = en;

  // angle scaling to binary angle
  logic signed [42:0] am_q [Lanes];
  logic               v1_q;
  logic signed [27:0] k;
  assign k = $signed(AngToBin);

  always_ff @(posedge clk_i) begin
    if (en) begin
      am_q[0] <= 43'(base_angle_i) * 43'(k);
      am_q[1] <= 43'(shoulder_angle_i) * 43'(k);
      am_q[2] <= 43'(elbow_angle_i) * 43'(k);
    end
  end

  logic [31:0] bin [Lanes];
  for (genvar l = 0; l < Lanes; l++) begin : g_bin
    logic signed [42:0] r;
    assign r      = am_q[l] + 43'sd128;
    assign bin[l] = r[39:8];
  end

  logic [31:0] ang [Lanes];
  assign ang[0] = bin[0];
  assign ang[1] = 32'h4000_0000 - bin[1];
  assign ang[2] = ang[1] - bin[2];

  // fold into a quarter turn either way
  logic signed [ZW-1:0] zf  [Lanes];
  logic                 nf  [Lanes];
  for (genvar l = 0; l < Lanes; l++) begin : g_fold
    logic signed [ZW-1:0] zs;
    assign zs = $signed({ang[l][31], ang[l]});
    always_comb begin
      zf[l] = zs;
      nf[l] = 1'b0;
      if (zs > $signed(33'h0_4000_0000)) begin
        zf[l] = zs - $signed(33'h0_8000_0000);
        nf[l] = 1'b1;
      end else if (zs < -$signed(33'h0_4000_0000)) begin
        zf[l] = zs + $signed(33'h0_8000_0000);
        nf[l] = 1'b1;
      end
    end
  end

  logic                 cv;
  logic signed [XW-1:0] cc [Lanes];
  logic signed [XW-1:0] ss [Lanes];

  fk3_cordic #(.STAGES(NStg)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v1_q),
    .z_i     (zf),
    .neg_i   (nf),
    .valid_o (cv),
    .cos_o   (cc),
    .sin_o   (ss)
  );

  // link products
  logic signed [20:0] l1s, l2s;
  assign l1s = $signed({1'b0, l1_q});
  assign l2s = $signed({1'b0, l2_q});

  logic signed [54:0] m_ce_q, m_cd_q, m_se_q, m_sd_q;
  logic signed [31:0] cb_q, sb_q, cb2_q, sb2_q;
  logic               vp1_q, vp2_q, vp3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_ce_q <= 55'(l1s) * 55'(cc[1]);
      m_cd_q <= 55'(l2s) * 55'(cc[2]);
      m_se_q <= 55'(l1s) * 55'(ss[1]);
      m_sd_q <= 55'(l2s) * 55'(ss[2]);
      cb_q   <= cc[0][31:0];
      sb_q   <= ss[0][31:0];
    end
  end

  // reach and height
  logic signed [55:0] hsum, zsum;
  logic signed [26:0] zr;
  assign hsum = 56'(m_ce_q) + 56'(m_cd_q) + 56'sd2097152;
  assign zsum = 56'(m_se_q) + 56'(m_sd_q) + 56'sd536870912;
  assign zr   = 27'($signed(zsum[55:30])) + 27'($signed(off_q));

  logic signed [30:0]     h_q;
  logic signed [OutW-1:0] pz_q, pz2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_q   <= hsum[52:22];
      pz_q  <= sat_out(zr);
      cb2_q <= cb_q;
      sb2_q <= sb_q;
    end
  end

  // projection by the base angle
  logic signed [62:0] px_m_q, py_m_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      px_m_q <= 63'(h_q) * 63'(cb2_q);
      py_m_q <= 63'(h_q) * 63'(sb2_q);
      pz2_q  <= pz_q;
    end
  end

  logic signed [62:0] pxr, pyr;
  assign pxr = px_m_q + 63'sd137438953472;
  assign pyr = py_m_q + 63'sd137438953472;

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_x_o <= sat_out(27'($signed(pxr[62:38])));
      pos_y_o <= sat_out(27'($signed(pyr[62:38])));
      pos_z_o <= pz2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q      <= 1'b0;
      vp1_q     <= 1'b0;
      vp2_q     <= 1'b0;
      vp3_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      v1_q      <= in_valid_i;
      vp1_q     <= cv;
      vp2_q     <= vp1_q;
      vp3_q     <= vp2_q;
      out_vld_q <= vp3_q;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule
`default_nettype wire

// File: src/fk3_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fk3_cordic
// pipelined rotation cordic, three lanes, one stage register per iteration
// ----------------------------------------------------------------------------
module fk3_cordic #(
  parameter int unsigned STAGES = fk3_pkg::CordicStagesDef
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  en_i,
  input  wire                                  valid_i,
  input  wire  logic signed [fk3_pkg::ZW-1:0]  z_i   [fk3_pkg::Lanes],
  input  wire                                  neg_i [fk3_pkg::Lanes],
  output logic                                 valid_o,
  output logic signed [fk3_pkg::XW-1:0]        cos_o [fk3_pkg::Lanes],
  output logic signed [fk3_pkg::XW-1:0]        sin_o [fk3_pkg::Lanes]
);
  import fk3_pkg::*;

  logic signed [XW-1:0] x_q   [STAGES+1][Lanes];
  logic signed [XW-1:0] y_q   [STAGES+1][Lanes];
  logic signed [ZW-1:0] z_q   [STAGES+1][Lanes];
  logic                 neg_q [STAGES+1][Lanes];
  logic [STAGES:0]      vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STAGES-1:0], valid_i};
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_in
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[0][l]   <= GainQ30;
        y_q[0][l]   <= '0;
        z_q[0][l]   <= z_i[l];
        neg_q[0][l] <= neg_i[l];
      end
    end
  end

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic signed [ZW-1:0] At = $signed({1'b0, atan_bin(s)});
    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      logic signed [XW-1:0] dx, dy;
      assign dx = y_q[s][l] >>> s;
      assign dy = x_q[s][l] >>> s;
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          neg_q[s+1][l] <= neg_q[s][l];
          if (!z_q[s][l][ZW-1]) begin
            x_q[s+1][l] <= x_q[s][l] - dx;
            y_q[s+1][l] <= y_q[s][l] + dy;
            z_q[s+1][l] <= z_q[s][l] - At;
          end else begin
            x_q[s+1][l] <= x_q[s][l] + dx;
            y_q[s+1][l] <= y_q[s][l] - dy;
            z_q[s+1][l] <= z_q[s][l] + At;
          end
        end
      end
    end
  end

  for (genvar l = 0; l < Lanes; l++) begin : g_out
    assign cos_o[l] = neg_q[STAGES][l] ? -x_q[STAGES][l] : x_q[STAGES][l];
    assign sin_o[l] = neg_q[STAGES][l] ? -y_q[STAGES][l] : y_q[STAGES][l];
  end

  assign valid_o = vld_q[STAGES];

endmodule
`default_nettype wire

// File: test/three_joint_arm_forward_kinematics_tb.sv
// ----------------------------------------------------------------------------
// three_joint_arm_forward_kinematics_tb
// self-checking bench for the three joint arm forward kinematics block: a
// bit-exact predictor of the cordic datapath computes each end point, random
// stalls on both handshakes, link and offset settings swept between phases
// ----------------------------------------------------------------------------
module three_joint_arm_forward_kinematics_tb;
  import fk3_pkg::*;

  localparam int unsigned NumStages = CordicStagesDef;
  localparam int unsigned Latency   = NumStages + 7;
  localparam longint      PosMax    = 2097151;

  typedef struct packed {
    logic signed [OutW-1:0] x;
    logic signed [OutW-1:0] y;
    logic signed [OutW-1:0] z;
  } arm_pos_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [IdxW-1:0]        cfg_idx_i = '0;
  logic [CfgW-1:0]        cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic signed [AngW-1:0] base_angle_i = '0;
  logic signed [AngW-1:0] shoulder_angle_i = '0;
  logic signed [AngW-1:0] elbow_angle_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic signed [OutW-1:0] pos_x_o;
  logic signed [OutW-1:0] pos_y_o;
  logic signed [OutW-1:0] pos_z_o;

  longint   upper_len, lower_len, z_offset;
  arm_pos_t pending_pos[$];
  int       err_cnt = 0;
  int       sent_cnt = 0;
  int       done_cnt = 0;
  int       sat_cnt = 0;
  bit       steady = 1'b0;

  longint atan_tab[24] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
  };

  three_joint_arm_forward_kinematics u_dut (.*);

  always #4 clk_i = ~clk_i;

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] to_turns(logic signed [AngW-1:0] a);
    longint p;
    p = round_sh(longint'(a) * 64'sd85445660, 8);
    return p[31:0];
  endfunction

  function automatic longint clamp_pos(longint v);
    if (v > PosMax) return PosMax;
    if (v < -PosMax) return -PosMax;
    return v;
  endfunction

  function automatic void cordic_sincos(input logic [31:0] ang, output longint c,
                                        output longint s);
    longint z, x, y, dx, dy;
    bit     flip;
    z = longint'(ang);
    x = longint'(GainQ30);
    y = 0;
    flip = 1'b0;
    if (ang[31]) z = z - 64'sh100000000;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000;
      flip = 1'b1;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000;
      flip = 1'b1;
    end
    for (int i = 0; i < NumStages && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - atan_tab[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + atan_tab[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic arm_pos_t end_point(logic signed [AngW-1:0] b, logic signed [AngW-1:0] sh,
                                         logic signed [AngW-1:0] el);
    logic [31:0] eb, db;
    longint      cb, sb, ce, se, cd, sd, h, zs, px, py, pz;
    arm_pos_t    r;
    eb = 32'h40000000 - to_turns(sh);
    db = eb - to_turns(el);
    cordic_sincos(to_turns(b), cb, sb);
    cordic_sincos(eb, ce, se);
    cordic_sincos(db, cd, sd);
    h  = round_sh(upper_len * ce + lower_len * cd, 22);
    zs = upper_len * se + lower_len * sd;
    px = clamp_pos(round_sh(h * cb, 38));
    py = clamp_pos(round_sh(h * sb, 38));
    pz = clamp_pos(round_sh(zs, 30) + z_offset);
    r.x = px[OutW-1:0];
    r.y = py[OutW-1:0];
    r.z = pz[OutW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", field, got, want,
             done_cnt);
    err_cnt++;
  endtask

  // request and result monitor
  always @(posedge clk_i) begin
    arm_pos_t want;
    if (rst_ni && in_valid_i && in_ready_o) begin
      want = end_point(base_angle_i, shoulder_angle_i, elbow_angle_i);
      if (want.x == PosMax || want.x == -PosMax || want.z == PosMax || want.z == -PosMax)
        sat_cnt++;
      pending_pos.push_back(want);
      sent_cnt++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_pos.size() == 0) begin
        report_mismatch("unexpected result", 0, 0);
      end else begin
        want = pending_pos.pop_front();
        if (pos_x_o !== want.x) report_mismatch("pos_x", pos_x_o, want.x);
        if (pos_y_o !== want.y) report_mismatch("pos_y", pos_y_o, want.y);
        if (pos_z_o !== want.z) report_mismatch("pos_z", pos_z_o, want.z);
      end
      done_cnt++;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 26);
  end

  task automatic send_angles(logic signed [AngW-1:0] b, logic signed [AngW-1:0] sh,
                             logic signed [AngW-1:0] el);
    int n;
    while (!steady && $urandom_range(99) < 26) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    base_angle_i = b;
    shoulder_angle_i = sh;
    elbow_angle_i = el;
    n = sent_cnt;
    wait (sent_cnt != n);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i = 1'b0;
    wait (pending_pos.size() == 0);
    repeat (Latency + 4) @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [IdxW-1:0] idx, logic [CfgW-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    case (idx)
      RegUpper:  upper_len = longint'(data[LenW-1:0]);
      RegLower:  lower_len = longint'(data[LenW-1:0]);
      RegOffset: z_offset = longint'($signed(data[OffW-1:0]));
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function automatic logic signed [AngW-1:0] rand_angle();
    if ($urandom_range(3) == 0) return AngW'($urandom);
    return AngW'($signed($urandom_range(25736)) - 12868);
  endfunction

  task automatic test_directed();
    logic signed [AngW-1:0] ext[8] = '{0, 1, -1, 12868, -12868, 6434, -16384, 16383};
    for (int i = 0; i < 8; i++) send_angles(ext[i], 0, 0);
    for (int i = 0; i < 8; i++) send_angles(0, ext[i], 0);
    for (int i = 0; i < 8; i++) send_angles(0, 0, ext[i]);
    send_angles(-16384, -16384, -16384);
    drain();
  endtask

  task automatic test_config();
    // reach and offset extremes, an unused index, bits beyond the field width
    cfg_write(RegUpper, 21'h1FFFFF);
    cfg_write(RegLower, 21'h0FFFFF);
    cfg_write(RegOffset, 21'sd1048575);
    cfg_write(2'd3, 21'h12345);
    for (int i = 0; i < 6; i++) send_angles(rand_angle(), rand_angle(), rand_angle());
    send_angles(0, 0, 0);
    send_angles(0, 12868, 0);
    drain();
    cfg_write(RegUpper, 21'd0);
    cfg_write(RegLower, 21'd0);
    cfg_write(RegOffset, -21'sd1048575);
    send_angles(0, 0, 0);
    send_angles(100, -200, 300);
    drain();
    cfg_write(RegOffset, 21'h100000);
    send_angles(12868, -6434, 12868);
    drain();
  endtask

  task automatic test_random();
    for (int ph = 0; ph < 5; ph++) begin
      cfg_write(RegUpper, CfgW'($urandom));
      cfg_write(RegLower, (ph == 4) ? CfgW'(LowerRst) : CfgW'($urandom));
      cfg_write(RegOffset, CfgW'($urandom));
      steady = (ph == 2);
      for (int i = 0; i < 320; i++) begin
        send_angles(rand_angle(), rand_angle(), rand_angle());
        if (i == 160) drain();
      end
      steady = 1'b0;
      drain();
    end
  endtask

  initial begin
    upper_len = longint'(UpperRst);
    lower_len = longint'(LowerRst);
    z_offset = longint'($signed(OffsetRst));
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_config();
    test_random();
    drain();
    $display("covered %0d requests, %0d results, %0d saturated near limits, 5 random setups",
             sent_cnt, done_cnt, sat_cnt);
    if (err_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout with %0d results pending", pending_pos.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule

// File: filelist.f
src/fk3_pkg.sv
src/fk3_cordic.sv
src/three_joint_arm_forward_kinematics.sv
test/three_joint_arm_forward_kinematics_tb.sv
